[rtl/sfs_pkg.sv]
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types, constants and register codes of the spring friction step core.
// ----------------------------------------------------------------------------
package sfs_pkg;

   localparam int NUM_SPRINGS = 64;
   localparam int SPRING_AW   = (NUM_SPRINGS > 1) ? $clog2(NUM_SPRINGS) : 1;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 88;
   localparam int CSR_ADDR_W = 5;

   localparam logic [38:0] FORCE_MAX = {39{1'b1}};
   localparam logic [47:0] RATIO_MAX = {48{1'b1}};

   localparam logic [2:0] REG_SPRING_STIFFNESS  = 3'd0;
   localparam logic [2:0] REG_STATIC_LIMIT      = 3'd1;
   localparam logic [2:0] REG_KINETIC_LIMIT     = 3'd2;
   localparam logic [2:0] REG_NORMAL_STIFFNESS  = 3'd3;
   localparam logic [2:0] REG_MEAN_NORMAL_FORCE = 3'd4;
   localparam logic [2:0] REG_LOCK_SPRINGS      = 3'd5;

   localparam logic [31:0] RST_SPRING_STIFFNESS  = 32'h0001_0000;
   localparam logic [31:0] RST_STATIC_LIMIT      = 32'h0001_0000;
   localparam logic [31:0] RST_KINETIC_LIMIT     = 32'h0000_8000;
   localparam logic [31:0] RST_NORMAL_STIFFNESS  = 32'h0001_0000;
   localparam logic [31:0] RST_MEAN_NORMAL_FORCE = 32'h0001_0000;

   typedef enum logic [2:0] {
      MUL_FN,
      MUL_T1,
      MUL_MAG,
      MUL_THRS,
      MUL_THRK,
      MUL_KS
   } mul_op_type;

   typedef enum logic {
      DIV_RATIO,
      DIV_OFFSET
   } div_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DISPATCH,
      ST_FN,
      ST_RATIO,
      ST_SQRT,
      ST_T1,
      ST_MAG,
      ST_THRS,
      ST_THRK,
      ST_CHECK,
      ST_KS,
      ST_OFFSET,
      ST_WRITE,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic       load;
      logic       mul_go;
      mul_op_type mul_op;
      logic       div_go;
      div_op_type div_op;
      logic       sqrt_go;
      logic       write;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic sqrt_done;
      logic in_range;
      logic is_init;
      logic contact;
      logic slip;
      logic ks_zero;
      logic last;
      logic out_busy;
   } sts_type;

   typedef struct packed {
      logic [31:0] spring_stiffness;
      logic [31:0] static_limit;
      logic [31:0] kinetic_limit;
      logic [31:0] normal_stiffness;
      logic [31:0] mean_normal_force;
      logic        lock_springs;
   } cfg_type;

endpackage

[rtl/sfs_mul.sv]
// ----------------------------------------------------------------------------
// sfs_mul
// Q16.16 multiply of a 48-bit by a 32-bit magnitude in two partial products,
// truncated and saturated to the force range.
// ----------------------------------------------------------------------------
module sfs_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [47:0] op_a,
   input  logic [31:0] op_b,
   output logic        done,
   output logic [38:0] product
);

   logic        busy_ff;
   logic        done_ff;
   logic [1:0]  phase_ff;
   logic [47:0] a_ff;
   logic [31:0] b_ff;
   logic [55:0] lo_ff;
   logic [55:0] hi_ff;
   logic [38:0] prod_ff;
   logic [79:0] sum_in;
   logic [63:0] shifted_in;
   logic [38:0] sat_in;
   logic        start;

   assign start      = !busy_ff && !done_ff && go;
   assign sum_in     = {24'd0, lo_ff} + {hi_ff, 24'd0};
   assign shifted_in = sum_in[79:16];
   assign sat_in     = (|shifted_in[63:39]) ? sfs_pkg::FORCE_MAX : shifted_in[38:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            phase_ff <= 2'd0;
         end else if (busy_ff) begin
            if (phase_ff == 2'd2) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               phase_ff <= phase_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      if (busy_ff) begin
         case (phase_ff)
            2'd0:    lo_ff   <= a_ff[23:0] * b_ff;
            2'd1:    hi_ff   <= a_ff[47:24] * b_ff;
            2'd2:    prod_ff <= sat_in;
            default: prod_ff <= prod_ff;
         endcase
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

[rtl/sfs_div.sv]
// ----------------------------------------------------------------------------
// sfs_div
// Restoring divider, 56-bit dividend by 40-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module sfs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [55:0] numer,
   input  logic [39:0] denom,
   output logic        done,
   output logic [55:0] quotient
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  count_ff;
   logic [39:0] rem_ff;
   logic [55:0] nq_ff;
   logic [39:0] den_ff;
   logic [40:0] trial_in;
   logic [40:0] diff_in;
   logic        ge_in;
   logic        start;

   assign start    = !busy_ff && !done_ff && go;
   assign trial_in = {rem_ff, nq_ff[55]};
   assign ge_in    = trial_in >= {1'b0, den_ff};
   assign diff_in  = ge_in ? (trial_in - {1'b0, den_ff}) : trial_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= 6'd0;
         end else if (busy_ff) begin
            if (count_ff == 6'd55) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + 6'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= 40'd0;
         nq_ff  <= numer;
         den_ff <= denom;
      end else if (busy_ff) begin
         rem_ff <= diff_in[39:0];
         nq_ff  <= {nq_ff[54:0], ge_in};
      end
   end

   assign done     = done_ff;
   assign quotient = nq_ff;

endmodule

[rtl/sfs_sqrt.sv]
// ----------------------------------------------------------------------------
// sfs_sqrt
// Digit-by-digit integer square root of a 64-bit value, one root bit
// per cycle.
// ----------------------------------------------------------------------------
module sfs_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  count_ff;
   logic [63:0] v_ff;
   logic [33:0] rem_ff;
   logic [31:0] root_ff;
   logic [35:0] part_in;
   logic [35:0] trial_in;
   logic [35:0] rem_in;
   logic        ge_in;
   logic        start;

   assign start    = !busy_ff && !done_ff && go;
   assign part_in  = {rem_ff, v_ff[63:62]};
   assign trial_in = {2'b00, root_ff, 2'b01};
   assign ge_in    = part_in >= trial_in;
   assign rem_in   = ge_in ? (part_in - trial_in) : part_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= 5'd0;
         end else if (busy_ff) begin
            if (count_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff    <= radicand;
         rem_ff  <= 34'd0;
         root_ff <= 32'd0;
      end else if (busy_ff) begin
         v_ff    <= {v_ff[61:0], 2'b00};
         rem_ff  <= rem_in[33:0];
         root_ff <= {root_ff[30:0], ge_in};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[rtl/sfs_datapath.sv]
// ----------------------------------------------------------------------------
// sfs_datapath
// Item registers, spring state stores, arithmetic units, force sums and the
// result register.
// ----------------------------------------------------------------------------
module sfs_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  sfs_pkg::cfg_type                    cfg,
   input  sfs_pkg::cmd_type                    cmd,
   output sfs_pkg::sts_type                    sts,
   input  logic [sfs_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sfs_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   logic [5:0]  idx_ff;
   logic [31:0] x_ff;
   logic [31:0] y_ff;
   logic [31:0] now_ff;
   logic [31:0] delay_ff;
   logic        action_ff;
   logic        last_ff;

   logic [31:0] anchor_mem [sfs_pkg::NUM_SPRINGS];
   logic [31:0] rt_mem     [sfs_pkg::NUM_SPRINGS];
   logic [31:0] anchor_rd_ff;
   logic [31:0] rt_rd_ff;
   logic [sfs_pkg::NUM_SPRINGS-1:0] attached_ff;
   logic [sfs_pkg::NUM_SPRINGS-1:0] rt_valid_ff;
   logic [6:0]  total_ff;
   logic [38:0] acc_n_ff;
   logic [39:0] acc_s_ff;
   logic        rsp_valid_ff;
   logic [sfs_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [38:0] fn_ff;
   logic [47:0] r_ff;
   logic [31:0] s_ff;
   logic [38:0] t1_ff;
   logic [38:0] mag_ff;
   logic [38:0] thrs_ff;
   logic [38:0] thrk_ff;
   logic [38:0] ks_ff;
   logic [55:0] off_ff;

   logic [sfs_pkg::SPRING_AW-1:0] addr;
   logic        att_cur;
   logic [31:0] rt_cur;
   logic [32:0] ny;
   logic [32:0] dx;
   logic [32:0] adx;
   logic        neg;
   logic [31:0] avg;

   logic [47:0] mul_a;
   logic [31:0] mul_b;
   logic        mul_done;
   logic [38:0] mul_res;
   logic [55:0] div_num;
   logic [39:0] div_den;
   logic        div_done;
   logic [55:0] div_q;
   logic        sqrt_done;
   logic [31:0] sqrt_res;

   logic [55:0] off_eff;
   logic [57:0] slip_wide;
   logic [31:0] slip_pos;
   logic [32:0] rt_sum;
   logic [31:0] rt_sat;

   logic        anchor_we;
   logic [31:0] anchor_wd;
   logic        rt_we;
   logic [31:0] rt_wd;
   logic        att_set;
   logic        att_clr;
   logic        acc_en;
   logic [38:0] mag_fin;
   logic [40:0] ft;
   logic [40:0] s_sum;
   logic [39:0] acc_s_in;
   logic [39:0] n_sum;
   logic [38:0] acc_n_in;

   assign addr    = sfs_pkg::SPRING_AW'(idx_ff);
   assign att_cur = attached_ff[addr];
   assign rt_cur  = rt_valid_ff[addr] ? rt_rd_ff : 32'd0;
   assign ny      = 33'd0 - {y_ff[31], y_ff};
   assign dx      = {x_ff[31], x_ff} - {anchor_rd_ff[31], anchor_rd_ff};
   assign adx     = dx[32] ? (33'd0 - dx) : dx;
   assign neg     = !dx[32] && (|dx);
   assign avg     = (cfg.mean_normal_force == 32'd0) ? 32'd1 : cfg.mean_normal_force;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff    <= req_tdata[5:0];
         x_ff      <= req_tdata[37:6];
         y_ff      <= req_tdata[69:38];
         now_ff    <= req_tdata[101:70];
         delay_ff  <= req_tdata[133:102];
         action_ff <= req_tuser;
         last_ff   <= req_tlast;
      end
   end

   always_comb begin
      mul_a = 48'd0;
      mul_b = 32'd0;
      case (cmd.mul_op)
         sfs_pkg::MUL_FN: begin
            mul_a = 48'(ny);
            mul_b = cfg.normal_stiffness;
         end
         sfs_pkg::MUL_T1: begin
            mul_a = 48'(adx);
            mul_b = cfg.spring_stiffness;
         end
         sfs_pkg::MUL_MAG: begin
            mul_a = 48'(t1_ff);
            mul_b = s_ff;
         end
         sfs_pkg::MUL_THRS: begin
            mul_a = r_ff;
            mul_b = cfg.static_limit;
         end
         sfs_pkg::MUL_THRK: begin
            mul_a = r_ff;
            mul_b = cfg.kinetic_limit;
         end
         sfs_pkg::MUL_KS: begin
            mul_a = 48'(s_ff);
            mul_b = cfg.spring_stiffness;
         end
         default: begin
            mul_a = 48'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   always_comb begin
      if (cmd.div_op == sfs_pkg::DIV_RATIO) begin
         div_num = {1'b0, fn_ff, 16'd0};
         div_den = {8'd0, avg};
      end else begin
         div_num = {1'b0, thrk_ff, 16'd0};
         div_den = {1'b0, ks_ff};
      end
   end

   sfs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (cmd.mul_go),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_res)
   );

   sfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .numer    (div_num),
      .denom    (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   sfs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.sqrt_go),
      .radicand ({r_ff, 16'd0}),
      .done     (sqrt_done),
      .root     (sqrt_res)
   );

   always_ff @(posedge clock) begin
      if (mul_done) begin
         case (cmd.mul_op)
            sfs_pkg::MUL_FN:   fn_ff   <= mul_res;
            sfs_pkg::MUL_T1:   t1_ff   <= mul_res;
            sfs_pkg::MUL_MAG:  mag_ff  <= mul_res;
            sfs_pkg::MUL_THRS: thrs_ff <= mul_res;
            sfs_pkg::MUL_THRK: thrk_ff <= mul_res;
            sfs_pkg::MUL_KS:   ks_ff   <= mul_res;
            default:           ks_ff   <= ks_ff;
         endcase
      end
      if (div_done) begin
         if (cmd.div_op == sfs_pkg::DIV_RATIO) begin
            r_ff <= (|div_q[55:48]) ? sfs_pkg::RATIO_MAX : div_q[47:0];
         end else begin
            off_ff <= div_q;
         end
      end
      if (sqrt_done) begin
         s_ff <= sqrt_res;
      end
   end

   assign off_eff   = (ks_ff == 39'd0) ? 56'h01_0000_0000_00 : off_ff;
   assign slip_wide = neg ? ({{26{x_ff[31]}}, x_ff} - {2'b00, off_eff})
                          : ({{26{x_ff[31]}}, x_ff} + {2'b00, off_eff});
   assign slip_pos  = ((&slip_wide[57:31]) || !(|slip_wide[57:31])) ? slip_wide[31:0]
                    : (slip_wide[57] ? 32'h8000_0000 : 32'h7FFF_FFFF);
   assign rt_sum    = {1'b0, now_ff} + {1'b0, delay_ff};
   assign rt_sat    = rt_sum[32] ? 32'hFFFF_FFFF : rt_sum[31:0];

   always_comb begin
      anchor_we = 1'b0;
      anchor_wd = x_ff;
      rt_we     = 1'b0;
      rt_wd     = 32'd0;
      att_set   = 1'b0;
      att_clr   = 1'b0;
      acc_en    = 1'b0;
      mag_fin   = mag_ff;
      if (cmd.write) begin
         if (action_ff) begin
            anchor_we = 1'b1;
            rt_we     = 1'b1;
            att_set   = !att_cur;
         end else if (!y_ff[31]) begin
            att_clr   = !cfg.lock_springs && att_cur;
            anchor_we = cfg.lock_springs;
         end else begin
            acc_en = 1'b1;
            if (att_cur) begin
               if (sts.slip) begin
                  att_clr   = 1'b1;
                  mag_fin   = thrk_ff;
                  anchor_we = 1'b1;
                  anchor_wd = slip_pos;
                  rt_we     = 1'b1;
                  rt_wd     = rt_sat;
               end
            end else begin
               if (sts.slip) begin
                  mag_fin   = thrk_ff;
                  anchor_we = 1'b1;
                  anchor_wd = slip_pos;
               end
               if (rt_cur < now_ff) begin
                  att_set   = 1'b1;
                  anchor_we = 1'b1;
                  anchor_wd = x_ff;
               end
            end
         end
      end
   end

   assign ft       = neg ? (41'd0 - {2'b00, mag_fin}) : {2'b00, mag_fin};
   assign s_sum    = {acc_s_ff[39], acc_s_ff} + ft;
   assign acc_s_in = (s_sum[40] == s_sum[39]) ? s_sum[39:0]
                   : (s_sum[40] ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF);
   assign n_sum    = {1'b0, acc_n_ff} + {1'b0, fn_ff};
   assign acc_n_in = n_sum[39] ? sfs_pkg::FORCE_MAX : n_sum[38:0];

   always_ff @(posedge clock) begin
      anchor_rd_ff <= anchor_mem[addr];
      rt_rd_ff     <= rt_mem[addr];
      if (anchor_we) begin
         anchor_mem[addr] <= anchor_wd;
      end
      if (rt_we) begin
         rt_mem[addr] <= rt_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attached_ff  <= '0;
         rt_valid_ff  <= '0;
         total_ff     <= 7'd0;
         acc_n_ff     <= 39'd0;
         acc_s_ff     <= 40'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (att_set) begin
            attached_ff[addr] <= 1'b1;
            total_ff          <= total_ff + 7'd1;
         end else if (att_clr) begin
            attached_ff[addr] <= 1'b0;
            total_ff          <= total_ff - 7'd1;
         end
         if (rt_we) begin
            rt_valid_ff[addr] <= 1'b1;
         end
         if (acc_en) begin
            acc_n_ff <= acc_n_in;
            acc_s_ff <= acc_s_in;
         end else if (cmd.emit) begin
            acc_n_ff <= 39'd0;
            acc_s_ff <= 40'd0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {2'b00, total_ff, acc_n_ff, acc_s_ff};
      end
   end

   always_comb begin
      sts.mul_done  = mul_done;
      sts.div_done  = div_done;
      sts.sqrt_done = sqrt_done;
      sts.in_range  = 32'(idx_ff) < 32'(sfs_pkg::NUM_SPRINGS);
      sts.is_init   = action_ff;
      sts.contact   = y_ff[31];
      sts.slip      = att_cur ? ((mag_ff > thrs_ff) && !cfg.lock_springs)
                              : (mag_ff > thrk_ff);
      sts.ks_zero   = ks_ff == 39'd0;
      sts.last      = last_ff;
      sts.out_busy  = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/sfs_ctrl.sv]
// ----------------------------------------------------------------------------
// sfs_ctrl
// Sequencer for one spring item: read state, run the arithmetic steps,
// write back and hand off the sums.
// ----------------------------------------------------------------------------
module sfs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  sfs_pkg::sts_type sts,
   output sfs_pkg::cmd_type cmd
);

   sfs_pkg::ctrl_state_type state_ff;
   sfs_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfs_pkg::ST_IDLE:     if (req_tvalid) state_in = sfs_pkg::ST_READ;
         sfs_pkg::ST_READ:     state_in = sfs_pkg::ST_DISPATCH;
         sfs_pkg::ST_DISPATCH: begin
            if (!sts.in_range) begin
               state_in = sfs_pkg::ST_FINISH;
            end else if (sts.is_init || !sts.contact) begin
               state_in = sfs_pkg::ST_WRITE;
            end else begin
               state_in = sfs_pkg::ST_FN;
            end
         end
         sfs_pkg::ST_FN:       if (sts.mul_done) state_in = sfs_pkg::ST_RATIO;
         sfs_pkg::ST_RATIO:    if (sts.div_done) state_in = sfs_pkg::ST_SQRT;
         sfs_pkg::ST_SQRT:     if (sts.sqrt_done) state_in = sfs_pkg::ST_T1;
         sfs_pkg::ST_T1:       if (sts.mul_done) state_in = sfs_pkg::ST_MAG;
         sfs_pkg::ST_MAG:      if (sts.mul_done) state_in = sfs_pkg::ST_THRS;
         sfs_pkg::ST_THRS:     if (sts.mul_done) state_in = sfs_pkg::ST_THRK;
         sfs_pkg::ST_THRK:     if (sts.mul_done) state_in = sfs_pkg::ST_CHECK;
         sfs_pkg::ST_CHECK:    state_in = sts.slip ? sfs_pkg::ST_KS : sfs_pkg::ST_WRITE;
         sfs_pkg::ST_KS:       if (sts.mul_done) state_in = sfs_pkg::ST_OFFSET;
         sfs_pkg::ST_OFFSET:   if (sts.ks_zero || sts.div_done) state_in = sfs_pkg::ST_WRITE;
         sfs_pkg::ST_WRITE:    state_in = sfs_pkg::ST_FINISH;
         sfs_pkg::ST_FINISH:   if (!sts.last || !sts.out_busy) state_in = sfs_pkg::ST_IDLE;
         default:              state_in = sfs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.mul_op  = sfs_pkg::MUL_FN;
      cmd.div_op  = sfs_pkg::DIV_RATIO;
      req_tready  = 1'b0;
      unique case (state_ff)
         sfs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         sfs_pkg::ST_FN: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = sfs_pkg::MUL_FN;
         end
         sfs_pkg::ST_RATIO: begin
            cmd.div_go = 1'b1;
            cmd.div_op = sfs_pkg::DIV_RATIO;
         end
         sfs_pkg::ST_SQRT:  cmd.sqrt_go = 1'b1;
         sfs_pkg::ST_T1: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = sfs_pkg::MUL_T1;
         end
         sfs_pkg::ST_MAG: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = sfs_pkg::MUL_MAG;
         end
         sfs_pkg::ST_THRS: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = sfs_pkg::MUL_THRS;
         end
         sfs_pkg::ST_THRK: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = sfs_pkg::MUL_THRK;
         end
         sfs_pkg::ST_KS: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = sfs_pkg::MUL_KS;
         end
         sfs_pkg::ST_OFFSET: begin
            cmd.div_go = !sts.ks_zero;
            cmd.div_op = sfs_pkg::DIV_OFFSET;
         end
         sfs_pkg::ST_WRITE: cmd.write = 1'b1;
         sfs_pkg::ST_FINISH: cmd.emit = sts.last && !sts.out_busy;
         sfs_pkg::ST_READ, sfs_pkg::ST_DISPATCH, sfs_pkg::ST_CHECK: begin
            cmd.load = 1'b0;
         end
         default: cmd.load = 1'b0;
      endcase
   end

endmodule

[rtl/spring_friction_step_core.sv]
// ----------------------------------------------------------------------------
// spring_friction_step_core
// Friction spring update per item with force sums sent on the last spring.
// Initialize, out-of-contact and out-of-range items skip the arithmetic steps;
// a spring in contact runs them, and a slip adds the k*s product and offset divide.
// Items are taken one at a time; the 56-step divider and 32-step square root,
// one bit per cycle, take most of the time of an item in contact.
// Reset clears attach flags, reattach times, count and sums; loads register defaults.
// ----------------------------------------------------------------------------
module spring_friction_step_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // spring_index[5:0], node_x[37:6], node_y[69:38], now_time[101:70],
   // reattach_delay[133:102], zero fill
   input  logic [sfs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // action[0]
   input  logic                               req_tuser,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // shear_sum[39:0], normal_sum[78:40], attached_count[85:79], zero fill
   output logic [sfs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sfs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   sfs_pkg::cfg_type cfg_ff;
   sfs_pkg::cmd_type cmd;
   sfs_pkg::sts_type sts;
   logic [2:0]       reg_idx;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spring_stiffness  <= sfs_pkg::RST_SPRING_STIFFNESS;
         cfg_ff.static_limit      <= sfs_pkg::RST_STATIC_LIMIT;
         cfg_ff.kinetic_limit     <= sfs_pkg::RST_KINETIC_LIMIT;
         cfg_ff.normal_stiffness  <= sfs_pkg::RST_NORMAL_STIFFNESS;
         cfg_ff.mean_normal_force <= sfs_pkg::RST_MEAN_NORMAL_FORCE;
         cfg_ff.lock_springs      <= 1'b0;
      end else if (csr_wr) begin
         unique case (reg_idx)
            sfs_pkg::REG_SPRING_STIFFNESS:  cfg_ff.spring_stiffness  <= csr_pwdata;
            sfs_pkg::REG_STATIC_LIMIT:      cfg_ff.static_limit      <= csr_pwdata;
            sfs_pkg::REG_KINETIC_LIMIT:     cfg_ff.kinetic_limit     <= csr_pwdata;
            sfs_pkg::REG_NORMAL_STIFFNESS:  cfg_ff.normal_stiffness  <= csr_pwdata;
            sfs_pkg::REG_MEAN_NORMAL_FORCE: cfg_ff.mean_normal_force <= csr_pwdata;
            sfs_pkg::REG_LOCK_SPRINGS:      cfg_ff.lock_springs      <= csr_pwdata[0];
            default:                        cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         sfs_pkg::REG_SPRING_STIFFNESS:  csr_prdata = cfg_ff.spring_stiffness;
         sfs_pkg::REG_STATIC_LIMIT:      csr_prdata = cfg_ff.static_limit;
         sfs_pkg::REG_KINETIC_LIMIT:     csr_prdata = cfg_ff.kinetic_limit;
         sfs_pkg::REG_NORMAL_STIFFNESS:  csr_prdata = cfg_ff.normal_stiffness;
         sfs_pkg::REG_MEAN_NORMAL_FORCE: csr_prdata = cfg_ff.mean_normal_force;
         sfs_pkg::REG_LOCK_SPRINGS:      csr_prdata = {31'd0, cfg_ff.lock_springs};
         default:                        csr_prdata = 32'd0;
      endcase
   end

   sfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sfs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[tb/tb_spring_friction_step_core.sv]
// ----------------------------------------------------------------------------
// tb_spring_friction_step_core
// Self-checking bench for the spring friction step core. A queue of spring
// transfers feeds a clocked driver, a clocked monitor predicts the force sums
// and the attached count in fixed point and compares every result transfer.
// Register settings change between phases, while the core is drained.
// ----------------------------------------------------------------------------
module tb_spring_friction_step_core;

   typedef struct {
      bit        act;
      bit [5:0]  idx;
      bit [31:0] x;
      bit [31:0] y;
      bit [31:0] now;
      bit [31:0] dly;
      bit        last;
   } spring_xfer_type;

   typedef struct {
      bit [39:0] shear;
      bit [38:0] normal;
      bit [6:0]  count;
   } step_sums_type;

   localparam bit [63:0] FMAX_Q = 64'd549755813887;
   localparam longint    FMIN_Q = -64'sd549755813888;
   localparam bit [63:0] RMAX_Q = 64'd281474976710655;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [sfs_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           req_tuser;
   logic                           req_tlast;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [sfs_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [sfs_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                    csr_pwdata;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;

   spring_friction_step_core dut (.*);

   // predictor state
   bit [31:0] k_cfg, fs_cfg, fk_cfg, kn_cfg, mean_cfg;
   bit        lock_cfg;
   int        anchor_q [64];
   bit        att_q [64];
   bit [31:0] reat_q [64];
   int        att_total;
   longint    shear_acc;
   bit [63:0] normal_acc;

   spring_xfer_type pending_q [$];
   step_sums_type   sums_due [$];
   bit              ever_set [64];
   int              sent_cnt, taken_cnt;
   int              err_cnt, res_cnt, slip_cnt;
   bit              calm;
   bit [31:0]       tick;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bit [63:0] qmul(bit [63:0] a, bit [63:0] b);
      bit [127:0] p;
      p = a * b;
      if (p[127:64] != 0) return FMAX_Q;
      p = p >> 16;
      return (p[63:0] > FMAX_Q) ? FMAX_Q : p[63:0];
   endfunction

   function automatic bit [63:0] floor_root(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic void slip_to(int i, longint x, bit neg, bit [63:0] fkr, bit [63:0] s);
      bit [63:0] ks, off;
      longint    p;
      ks = qmul(k_cfg, s);
      off = (ks != 0) ? (fkr << 16) / ks : (64'd1 << 40);
      p = neg ? x - longint'(off) : x + longint'(off);
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      anchor_q[i] = int'(p);
      slip_cnt++;
   endfunction

   function automatic void move_spring(int i, longint x, longint y, bit [31:0] now,
                                       bit [31:0] dly);
      bit [63:0] fn, r, s, adx, mag, thrs, thrk, avg, t;
      longint    dx, ft;
      bit        neg;
      if (y >= 0) begin
         if (!lock_cfg && att_q[i]) begin
            att_q[i] = 0;
            att_total--;
         end
         if (lock_cfg) anchor_q[i] = int'(x);
         return;
      end
      fn = qmul(64'(-y), kn_cfg);
      avg = (mean_cfg != 0) ? 64'(mean_cfg) : 64'd1;
      r = (fn << 16) / avg;
      if (r > RMAX_Q) r = RMAX_Q;
      s = floor_root(r << 16);
      dx = x - longint'(anchor_q[i]);
      neg = dx > 0;
      adx = (dx < 0) ? 64'(-dx) : 64'(dx);
      mag = qmul(qmul(adx, k_cfg), s);
      thrs = qmul(fs_cfg, r);
      thrk = qmul(fk_cfg, r);
      if (att_q[i]) begin
         if (mag > thrs && !lock_cfg) begin
            t = 64'(now) + 64'(dly);
            att_q[i] = 0;
            att_total--;
            mag = thrk;
            slip_to(i, x, neg, thrk, s);
            reat_q[i] = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
         end
      end else begin
         if (mag > thrk) begin
            mag = thrk;
            slip_to(i, x, neg, thrk, s);
         end
         if (reat_q[i] < now) begin
            att_q[i] = 1;
            anchor_q[i] = int'(x);
            att_total++;
         end
      end
      ft = neg ? -longint'(mag) : longint'(mag);
      normal_acc = normal_acc + fn;
      if (normal_acc > FMAX_Q) normal_acc = FMAX_Q;
      shear_acc = shear_acc + ft;
      if (shear_acc > longint'(FMAX_Q)) shear_acc = longint'(FMAX_Q);
      if (shear_acc < FMIN_Q) shear_acc = FMIN_Q;
   endfunction

   function automatic void advance_spring(spring_xfer_type it);
      step_sums_type e;
      int            i;
      i = it.idx;
      if (it.act) begin
         anchor_q[i] = int'(signed'(it.x));
         if (!att_q[i]) begin
            att_q[i] = 1;
            att_total++;
         end
         reat_q[i] = 0;
      end else begin
         move_spring(i, longint'(signed'(it.x)), longint'(signed'(it.y)), it.now, it.dly);
      end
      if (it.last) begin
         e.shear = shear_acc[39:0];
         e.normal = normal_acc[38:0];
         e.count = (att_total > 127) ? 7'd127 : 7'(att_total);
         sums_due.insert(sums_due.size(), e);
         shear_acc = 0;
         normal_acc = 0;
      end
   endfunction

   // driver
   always @(negedge clock) begin
      spring_xfer_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= 20);
         if (!req_tvalid || sent_cnt == taken_cnt) begin
            if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 20)) begin
               it = pending_q.pop_front();
               req_tdata <= {2'b00, it.dly, it.now, it.y, it.x, it.idx};
               req_tuser <= it.act;
               req_tlast <= it.last;
               req_tvalid <= 1'b1;
               sent_cnt++;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      spring_xfer_type it;
      step_sums_type   e;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            it.idx = req_tdata[5:0];
            it.x = req_tdata[37:6];
            it.y = req_tdata[69:38];
            it.now = req_tdata[101:70];
            it.dly = req_tdata[133:102];
            it.act = req_tuser;
            it.last = req_tlast;
            advance_spring(it);
            taken_cnt++;
         end
         if (rsp_tvalid && rsp_tready) begin
            res_cnt++;
            if (sums_due.size() == 0) begin
               $error("result transfer with no result expected");
               err_cnt++;
            end else begin
               e = sums_due.pop_front();
               if (rsp_tdata[39:0] !== e.shear) begin
                  $error("shear_sum: expected %h, got %h", e.shear, rsp_tdata[39:0]);
                  err_cnt++;
               end
               if (rsp_tdata[78:40] !== e.normal) begin
                  $error("normal_sum: expected %h, got %h", e.normal, rsp_tdata[78:40]);
                  err_cnt++;
               end
               if (rsp_tdata[85:79] !== e.count) begin
                  $error("attached_count: expected %0d, got %0d", e.count,
                         rsp_tdata[85:79]);
                  err_cnt++;
               end
            end
         end
      end
   end

   task automatic csr_write(logic [2:0] reg_id, bit [31:0] v);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {reg_id, 2'b00};
      csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (reg_id)
         sfs_pkg::REG_SPRING_STIFFNESS:  k_cfg = v;
         sfs_pkg::REG_STATIC_LIMIT:      fs_cfg = v;
         sfs_pkg::REG_KINETIC_LIMIT:     fk_cfg = v;
         sfs_pkg::REG_NORMAL_STIFFNESS:  kn_cfg = v;
         sfs_pkg::REG_MEAN_NORMAL_FORCE: mean_cfg = v;
         sfs_pkg::REG_LOCK_SPRINGS:      lock_cfg = v[0];
         default: ;
      endcase
   endtask

   task automatic set_all(bit [31:0] k, bit [31:0] fs, bit [31:0] fk, bit [31:0] kn,
                          bit [31:0] mean, bit lock);
      csr_write(sfs_pkg::REG_SPRING_STIFFNESS, k);
      csr_write(sfs_pkg::REG_STATIC_LIMIT, fs);
      csr_write(sfs_pkg::REG_KINETIC_LIMIT, fk);
      csr_write(sfs_pkg::REG_NORMAL_STIFFNESS, kn);
      csr_write(sfs_pkg::REG_MEAN_NORMAL_FORCE, mean);
      csr_write(sfs_pkg::REG_LOCK_SPRINGS, {31'd0, lock});
   endtask

   task automatic drain();
      while (!(pending_q.size() == 0 && sent_cnt == taken_cnt && sums_due.size() == 0))
         @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   // queue one transfer; never let a contact update read an anchor not yet set
   task automatic push_xfer(bit act, bit [5:0] idx, bit [31:0] x, bit [31:0] y,
                            bit [31:0] now, bit [31:0] dly, bit last);
      spring_xfer_type it;
      if (!act && !ever_set[idx] && y[31]) act = 1'b1;
      if (act) ever_set[idx] = 1'b1;
      it = '{act, idx, x, y, now, dly, last};
      pending_q.insert(pending_q.size(), it);
   endtask

   task automatic random_steps(int n_items);
      int        cnt, m, j;
      bit [5:0]  base, idx;
      bit [31:0] x, y, dly;
      cnt = 0;
      while (cnt < n_items) begin
         m = $urandom_range(1, 6);
         base = 6'($urandom_range(0, 63));
         tick = ($urandom_range(0, 49) == 0) ? $urandom() : tick + $urandom_range(0, 40);
         for (j = 0; j < m; j++) begin
            idx = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : base + 6'(j);
            case ($urandom_range(0, 9))
               0:       y = $urandom();
               1, 2:    y = $urandom_range(0, 3 * 65536);
               default: y = -32'($urandom_range(1, 3 * 65536));
            endcase
            x = ($urandom_range(0, 9) == 0) ? $urandom()
                : 32'($urandom_range(0, 8 * 65536)) - 32'(4 * 65536);
            dly = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 60);
            push_xfer($urandom_range(0, 99) < 8, idx, x, y, tick, dly,
                      (j == m - 1) || ($urandom_range(0, 19) == 0));
            cnt++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      k_cfg = sfs_pkg::RST_SPRING_STIFFNESS;
      fs_cfg = sfs_pkg::RST_STATIC_LIMIT;
      fk_cfg = sfs_pkg::RST_KINETIC_LIMIT;
      kn_cfg = sfs_pkg::RST_NORMAL_STIFFNESS;
      mean_cfg = sfs_pkg::RST_MEAN_NORMAL_FORCE;
      lock_cfg = 1'b0;
      foreach (anchor_q[i]) begin
         anchor_q[i] = 0;
         att_q[i] = 0;
         reat_q[i] = 0;
         ever_set[i] = 0;
      end
      att_total = 0;
      shear_acc = 0;
      normal_acc = 0;
      sent_cnt = 0;
      taken_cnt = 0;
      err_cnt = 0;
      res_cnt = 0;
      slip_cnt = 0;
      calm = 1'b0;
      tick = 100;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: defaults, extremes, slip, reattach, overflow of reattach time
      push_xfer(1, 0, 32'h0, 32'h0, 0, 0, 1);
      push_xfer(1, 63, 32'h7FFF_FFFF, 32'h0, 0, 0, 0);
      push_xfer(0, 0, 32'h0000_0100, 32'hFFFF_0000, 10, 5, 0);
      push_xfer(0, 0, 32'h0008_0000, 32'hFFFF_0000, 11, 5, 0);
      push_xfer(0, 0, 32'h0009_0000, 32'hFFFF_0000, 20, 5, 0);
      push_xfer(0, 63, 32'h8000_0000, 32'h8000_0000, 21, 32'hFFFF_FFFF, 1);
      push_xfer(0, 63, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1);
      push_xfer(0, 0, 32'h0, 32'h0, 30, 0, 0);
      push_xfer(0, 0, 32'h0, 32'h7FFF_FFFF, 31, 0, 1);
      push_xfer(0, 5, 32'h1234_5678, 32'h0000_0001, 32, 0, 0);
      push_xfer(1, 5, 32'h8000_0000, 32'h8000_0000, 33, 32'hFFFF_FFFF, 0);
      push_xfer(1, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 34, 0, 1);
      push_xfer(0, 5, 32'h7FFF_FFFF, 32'h8000_0000, 35, 32'hFFFF_FFFF, 1);
      push_xfer(0, 5, 32'h0, 32'hFFF0_0000, 36, 0, 1);
      random_steps(80);
      drain();

      set_all(32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 32'h0001_0000, 1);
      push_xfer(0, 0, 32'h0100_0000, 32'h0000_0010, tick, 0, 0);
      push_xfer(0, 0, 32'h0400_0000, 32'hFFFF_0000, tick, 0, 1);
      random_steps(80);
      drain();

      // tiny stiffness and no static hold: slip with a vanishing k*s
      set_all(32'h0000_0001, 32'h0, $urandom(), 32'h0000_0100, 32'h0001_0000, 0);
      push_xfer(1, 7, 32'h0, 32'h0, tick, 0, 0);
      push_xfer(0, 7, 32'h7FFF_0000, 32'hFFFF_FF00, tick, 3, 1);
      random_steps(80);
      drain();

      set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 0);
      random_steps(80);
      drain();

      set_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0);
      random_steps(60);
      drain();

      calm = 1'b1;
      set_all($urandom_range(0, 4 * 65536), $urandom_range(0, 4 * 65536),
              $urandom_range(0, 2 * 65536), $urandom_range(0, 4 * 65536),
              $urandom_range(1, 4 * 65536), 0);
      random_steps(100);
      drain();
      calm = 1'b0;

      repeat (4) begin
         set_all($urandom_range(0, 4 * 65536), $urandom_range(0, 4 * 65536),
                 $urandom_range(0, 2 * 65536), $urandom_range(0, 4 * 65536),
                 $urandom_range(1, 4 * 65536), $urandom_range(0, 3) == 0);
         random_steps(80);
         drain();
      end

      $display("%0d spring transfers in ten register settings, %0d step results checked,",
               taken_cnt, res_cnt);
      $display("%0d slips predicted; lock, zero mean and saturating settings included.",
               slip_cnt);
      if (err_cnt == 0)
         $display("tb_spring_friction_step_core: clean");
      else
         $display("tb_spring_friction_step_core: errors");
      $finish;
   end

   initial begin
      #(12 * 3000000);
      $display("tb_spring_friction_step_core: errors");
      $finish;
   end

endmodule

[files.f]
rtl/sfs_pkg.sv
rtl/sfs_mul.sv
rtl/sfs_div.sv
rtl/sfs_sqrt.sv
rtl/sfs_datapath.sv
rtl/sfs_ctrl.sv
rtl/spring_friction_step_core.sv
tb/tb_spring_friction_step_core.sv
